@@ src/fault_latch_table_top_defines.svh @@
// Assertion macros used by the fault latch table top level.
`ifndef FAULT_LATCH_TABLE_TOP_DEFINES_SVH
`define FAULT_LATCH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define FLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define FLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fla_pkg.sv @@
// Types, codes and helper functions for the fault latch table.
`timescale 1ns / 1ps
`default_nettype none

package fla_pkg;

  // Operation codes carried with each input transfer
  typedef enum logic [1:0] {
    OP_REPORT    = 2'd0,
    OP_CLEAR_ONE = 2'd1,
    OP_CLEAR_ALL = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  // Fault codes with special handling
  localparam logic [3:0] CODE_NONE    = 4'd0;
  localparam logic [3:0] CODE_CRIT_LO = 4'd6;
  localparam logic [3:0] CODE_CRIT_HI = 4'd9;
  localparam logic [3:0] CODE_ESTOP   = 4'd10;
  localparam logic [3:0] CODE_MAP_LO  = 4'd1;
  localparam logic [3:0] CODE_MAP_HI  = 4'd10;

  // Severity levels
  localparam logic [1:0] SEV_WARNING   = 2'd0;
  localparam logic [1:0] SEV_CRITICAL  = 2'd1;
  localparam logic [1:0] SEV_EMERGENCY = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_SUMMARY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic load;
  } cmd_t;

  // Result item, clear_done in the lowest bit
  typedef struct packed {
    logic [3:0] entry_count;
    logic [9:0] active_map;
    logic [1:0] top_severity;
    logic [3:0] top_code;
    logic       top_valid;
    logic       may_exit;
    logic       code_active;
    logic       any_active;
    logic       safe_state;
    logic       clear_done;
  } result_t;

  // Fixed severity of each fault code
  function automatic logic [1:0] sev_for(input logic [3:0] code);
    logic [1:0] sev;
    sev = SEV_WARNING;
    if (code >= CODE_CRIT_LO && code <= CODE_CRIT_HI) begin
      sev = SEV_CRITICAL;
    end else if (code == CODE_ESTOP) begin
      sev = SEV_EMERGENCY;
    end
    return sev;
  endfunction

endpackage

`default_nettype wire

@@ src/fla_ctrl.sv @@
// Sequencing controller for the fault latch table: handshakes and datapath commands.
`timescale 1ns / 1ps
`default_nettype none

module fla_ctrl import fla_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic   m_tvalid_next;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid & ~m_tready;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_SUMMARY;
      end
      S_SUMMARY: begin
        // load only once the previous result has left the output register
        if (!m_tvalid || m_tready) begin
          cmd.load      = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/fla_datapath.sv @@
// Fault table storage, lookup, update and status summary datapath.
`timescale 1ns / 1ps
`default_nettype none

module fla_datapath import fla_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  input  wire logic [1:0] in_op,
  input  wire logic [3:0] in_code,
  output result_t         res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Captured item
  op_t        op_q;
  logic [3:0] code_q;

  // Table storage
  logic [3:0]             entry_code [TABLE_DEPTH];
  logic [1:0]             entry_sev  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_active;
  logic [CNT_W-1:0]       stored_count;
  logic                   safe_latch;

  // Lookup results
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             match_any;
  logic [IDX_W-1:0] match_idx;
  logic             cleared;

  // Derived controls for the update step
  logic       room;
  logic       report_new;
  logic [1:0] code_sev;

  // Summary terms
  result_t    sum;
  logic       sum_emerg;
  logic       sum_crit;
  logic [1:0] sum_max;

  assign room       = stored_count < CNT_W'(TABLE_DEPTH);
  assign code_sev   = sev_for(code_q);
  assign report_new = (op_q == OP_REPORT) && (code_q != CODE_NONE) && !hit && room;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(in_op);
      code_q <= in_code;
    end
  end

  // Search stored entries for the captured code, first in table order wins
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < stored_count && entry_code[i] == code_q) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit     <= match_any;
      hit_idx <= match_idx;
    end
  end

  // Append a new entry's code and severity
  always_ff @(posedge clk) begin
    if (cmd.update && report_new) begin
      entry_code[stored_count[IDX_W-1:0]] <= code_q;
      entry_sev[stored_count[IDX_W-1:0]]  <= code_sev;
    end
  end

  // Active flags, fill count and safe-state latch
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_active <= '0;
      stored_count <= '0;
      safe_latch   <= 1'b0;
    end else if (cmd.update) begin
      case (op_q)
        OP_REPORT: begin
          if (code_q != CODE_NONE) begin
            if (hit) begin
              entry_active[hit_idx] <= 1'b1;
            end else if (room) begin
              entry_active[stored_count[IDX_W-1:0]] <= 1'b1;
              stored_count <= stored_count + CNT_W'(1);
            end
            // stored severity always equals the code's fixed severity
            if ((hit || room) && code_sev >= SEV_CRITICAL) begin
              safe_latch <= 1'b1;
            end
          end
        end
        OP_CLEAR_ONE: begin
          if (code_q != CODE_ESTOP && hit) begin
            entry_active[hit_idx] <= 1'b0;
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) < stored_count && entry_code[i] != CODE_ESTOP) begin
              entry_active[i] <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Clear-one outcome
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cleared <= (op_q == OP_CLEAR_ONE) && (code_q != CODE_ESTOP) && hit;
    end
  end

  // Reductions over active entries
  always_comb begin
    sum       = '0;
    sum_emerg = 1'b0;
    sum_crit  = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (entry_active[i]) begin
        sum.any_active = 1'b1;
        if (entry_code[i] == code_q) begin
          sum.code_active = 1'b1;
        end
        if (entry_sev[i] == SEV_EMERGENCY) begin
          sum_emerg = 1'b1;
        end
        if (entry_sev[i] == SEV_CRITICAL) begin
          sum_crit = 1'b1;
        end
        if (entry_code[i] >= CODE_MAP_LO && entry_code[i] <= CODE_MAP_HI) begin
          sum.active_map[entry_code[i] - CODE_MAP_LO] = 1'b1;
        end
      end
    end
    sum_max = sum_emerg ? SEV_EMERGENCY : (sum_crit ? SEV_CRITICAL : SEV_WARNING);
    // first active entry at the highest severity
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (entry_active[i] && entry_sev[i] == sum_max) begin
        sum.top_valid    = 1'b1;
        sum.top_code     = entry_code[i];
        sum.top_severity = entry_sev[i];
      end
    end
    sum.may_exit    = ~(sum_emerg | sum_crit);
    sum.clear_done  = cleared;
    sum.safe_state  = safe_latch;
    sum.entry_count = 4'(stored_count);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= sum;
    end
  end

endmodule

`default_nettype wire

@@ src/fault_latch_table_top.sv @@
// Sequence: after the input transfer the controller steps through lookup, update and
//   summary; the result is loaded in summary and m_tvalid rises with it.
// Input is taken only in idle, so one item is in work at a time; a held result keeps the
//   controller in summary, so the next input transfer waits until the result leaves.
// Reset: rst returns the controller to idle, drops the output valid, and clears all active
//   flags, the fill count and the safe-state latch; stored codes and severities are not
//   cleared and are read only below the count.
`timescale 1ns / 1ps
`default_nettype none
`include "fault_latch_table_top_defines.svh"

module fault_latch_table_top import fla_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // op[1:0], fault_code[5:2], zero[7:6]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // clear_done[0], safe_state[1], any_active[2],
                                      // code_active[3], may_exit[4], top_valid[5],
                                      // top_code[9:6], top_severity[11:10],
                                      // active_map[21:12], entry_count[25:22], zero[31:26]
);

  cmd_t    cmd;
  result_t res;

  // Controller
  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Datapath
  fla_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_op   (s_tdata[1:0]),
    .in_code (s_tdata[5:2]),
    .res     (res)
  );

  assign m_tdata = {6'b0, res};

  // Checks
  `FLT_ASSERT_NOW(a_top_matches_any, m_tvalid, m_tdata[5] == m_tdata[2], "top_valid differs from any_active")
  `FLT_ASSERT_NOW(a_exit_blocked_sev, m_tvalid && !m_tdata[4], m_tdata[5] && m_tdata[11:10] != SEV_WARNING, "may_exit low without a critical top fault")
  `FLT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready && !cmd.load, "new item taken while one is in work")

endmodule

`default_nettype wire
